/* rtl/two_disjoint_paths_min_cost_core_defines.svh */
// ---------------------------------------------------------------------------
// two_disjoint_paths_min_cost_core defines
// assertion macros used by tdpmc_dp
// ---------------------------------------------------------------------------
`ifndef TWO_DISJOINT_PATHS_MIN_COST_CORE_DEFINES_SVH
`define TWO_DISJOINT_PATHS_MIN_COST_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TDPMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TDPMC_NEVER(label, cond, msg) \
   `TDPMC_ASSERT(label, !(cond), msg)

`endif

/* rtl/tdpmc_pkg.sv */
// ---------------------------------------------------------------------------
// tdpmc_pkg
// shared types and constants of the two disjoint paths min cost core
// ---------------------------------------------------------------------------
package tdpmc_pkg;

   localparam int COST_W   = 16;  // input edge cost
   localparam int EDGE_W   = 18;  // stored signed edge cost
   localparam int DIST_W   = 26;  // signed path distance
   localparam int SUM_W    = 24;  // result cost
   localparam int NODE_IW  = 8;   // node number on the input
   localparam logic [SUM_W-1:0] COST_LIMIT = '1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR_STEP,
      OP_LOAD_FWD,
      OP_LOAD_BACK,
      OP_RUN_START,
      OP_PASS_START,
      OP_U_READ,
      OP_U_LATCH,
      OP_REL_ISSUE,
      OP_REL_EVAL,
      OP_NEXT_U,
      OP_NEXT_ROUND,
      OP_AUG_START,
      OP_AUG_PRED,
      OP_AUG_FWD,
      OP_AUG_BACK,
      OP_AUG_WFWD,
      OP_AUG_WBACK,
      OP_RESULT
   } tdpmc_op_type;

   typedef struct packed {
      logic clr_last;
      logic item_last;
      logic n_small;
      logic u_reach;
      logic u_last;
      logic v_last;
      logic round_last;
      logic changed;
      logic dest_reach;
      logic aug_done;
      logic two_paths;
      logic out_free;
   } tdpmc_status_type;

endpackage

/* rtl/tdpmc_dp.sv */
// ---------------------------------------------------------------------------
// tdpmc_dp
// edge memory, distance and predecessor stores, counters and result register
// ---------------------------------------------------------------------------
`include "two_disjoint_paths_min_cost_core_defines.svh"

module tdpmc_dp #(
   parameter int MAX_NODES = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tdpmc_pkg::tdpmc_op_type     op,
   output tdpmc_pkg::tdpmc_status_type status,
   input  logic [31:0]                 req_tdata,
   input  logic                        req_tuser,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,
   output logic                        rsp_tuser,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data
);

   localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int CMP_W  = (CNT_W > tdpmc_pkg::NODE_IW) ? CNT_W : tdpmc_pkg::NODE_IW;
   localparam int ADDR_W = 2 * NODE_W;
   localparam int MEM_W  = tdpmc_pkg::EDGE_W + 1;
   localparam int EW     = tdpmc_pkg::EDGE_W;
   localparam int DW     = tdpmc_pkg::DIST_W;
   localparam int SW     = tdpmc_pkg::SUM_W + 3;

   // memories
   logic [MEM_W-1:0]  edge_mem [2**ADDR_W];
   logic [DW-1:0]     dist_mem [MAX_NODES];
   logic [NODE_W-1:0] pred_mem [MAX_NODES];

   logic [MEM_W-1:0]  edge_rd_ff;
   logic [DW-1:0]     dist_rd_ff;
   logic [NODE_W-1:0] pred_rd_ff;

   logic [ADDR_W-1:0] edge_addr;
   logic              edge_we, edge_re;
   logic [MEM_W-1:0]  edge_wdata;
   logic [NODE_W-1:0] dist_addr;
   logic              dist_we, dist_re;
   logic [DW-1:0]     dist_wdata;
   logic              pred_we, pred_re;

   // control and payload registers
   logic [7:0]           node_count_ff;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [NODE_W-1:0]    x_ff, y_ff;
   logic [EW-1:0]        cost_ff;
   logic                 edge_ok_ff, last_ff;
   logic [CNT_W-1:0]     n_ff, round_ff, steps_ff;
   logic [NODE_W-1:0]    u_ff, v_ff, now_ff, p_ff;
   logic                 changed_ff;
   logic [MAX_NODES-1:0] reach_ff;
   logic signed [DW-1:0] du_ff;
   logic [MEM_W-1:0]     fwd_ff, back_ff;
   logic [1:0]           paths_ff;
   logic signed [SW-1:0] sum_ff;
   logic                 rsp_valid_ff, rsp_found_ff;
   logic [tdpmc_pkg::SUM_W-1:0] rsp_cost_ff;

   // input item decode
   logic [tdpmc_pkg::NODE_IW-1:0] in_a, in_b;
   logic [tdpmc_pkg::NODE_IW:0]   a_m1, b_m1;
   logic [NODE_W-1:0]             in_x, in_y;
   logic                          in_ok;
   logic [CMP_W-1:0]              nc_cmp;
   logic [CNT_W-1:0]              n_sat;
   logic [NODE_W-1:0]             dest;

   assign in_a = req_tdata[7:0];
   assign in_b = req_tdata[15:8];
   assign a_m1 = {1'b0, in_a} - 9'd1;
   assign b_m1 = {1'b0, in_b} - 9'd1;
   assign in_x = NODE_W'(a_m1);
   assign in_y = NODE_W'(b_m1);
   assign in_ok = req_tuser && (in_a != '0) && (in_b != '0) &&
                  (CMP_W'(in_a) <= CMP_W'(MAX_NODES)) && (CMP_W'(in_b) <= CMP_W'(MAX_NODES));
   assign nc_cmp = CMP_W'(node_count_ff);
   assign n_sat  = (nc_cmp > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(nc_cmp);
   assign dest   = NODE_W'(n_ff - CNT_W'(1));

   // relaxation
   logic signed [EW-1:0]  cost_s, fwd_cost_s;
   logic signed [DW-1:0]  dist_v;
   logic signed [DW:0]    cand;
   logic                  relax;

   assign cost_s     = $signed(edge_rd_ff[EW-1:0]);
   assign fwd_cost_s = $signed(fwd_ff[EW-1:0]);
   assign dist_v     = $signed(dist_rd_ff);
   assign cand       = (DW+1)'(du_ff) + (DW+1)'(cost_s);
   assign relax      = edge_rd_ff[EW] && (!reach_ff[v_ff] || (cand < (DW+1)'(dist_v)));

   always_comb begin
      edge_addr  = clr_addr_ff;
      edge_we    = 1'b0;
      edge_re    = 1'b0;
      edge_wdata = '0;
      dist_addr  = v_ff;
      dist_we    = 1'b0;
      dist_re    = 1'b0;
      dist_wdata = '0;
      pred_we    = 1'b0;
      pred_re    = 1'b0;
      unique case (op)
         tdpmc_pkg::OP_CLEAR_STEP: begin
            edge_we = 1'b1;
         end
         tdpmc_pkg::OP_LOAD_FWD: begin
            edge_addr  = {in_x, in_y};
            edge_we    = in_ok;
            edge_wdata = {1'b1, 2'b00, req_tdata[31:16]};
         end
         tdpmc_pkg::OP_LOAD_BACK: begin
            edge_addr  = {y_ff, x_ff};
            edge_we    = edge_ok_ff;
            edge_wdata = {1'b1, cost_ff};
         end
         tdpmc_pkg::OP_PASS_START: begin
            dist_addr = '0;
            dist_we   = 1'b1;
         end
         tdpmc_pkg::OP_U_READ: begin
            dist_addr = u_ff;
            dist_re   = 1'b1;
         end
         tdpmc_pkg::OP_REL_ISSUE: begin
            edge_addr = {u_ff, v_ff};
            edge_re   = 1'b1;
            dist_re   = 1'b1;
         end
         tdpmc_pkg::OP_REL_EVAL: begin
            dist_we    = relax;
            dist_wdata = DW'(cand);
            pred_we    = relax;
         end
         tdpmc_pkg::OP_AUG_PRED: begin
            pred_re = 1'b1;
         end
         tdpmc_pkg::OP_AUG_FWD: begin
            edge_addr = {pred_rd_ff, now_ff};
            edge_re   = 1'b1;
         end
         tdpmc_pkg::OP_AUG_BACK: begin
            edge_addr = {now_ff, p_ff};
            edge_re   = 1'b1;
         end
         tdpmc_pkg::OP_AUG_WFWD: begin
            edge_addr = {p_ff, now_ff};
            edge_we   = 1'b1;
         end
         tdpmc_pkg::OP_AUG_WBACK: begin
            edge_addr  = {now_ff, p_ff};
            edge_we    = 1'b1;
            edge_wdata = {back_ff[EW], EW'(-fwd_cost_s)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_addr] <= edge_wdata;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[edge_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_addr] <= dist_wdata;
      end
      if (dist_re) begin
         dist_rd_ff <= dist_mem[dist_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pred_we) begin
         pred_mem[v_ff] <= u_ff;
      end
      if (pred_re) begin
         pred_rd_ff <= pred_mem[now_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (op)
         tdpmc_pkg::OP_LOAD_FWD: begin
            x_ff       <= in_x;
            y_ff       <= in_y;
            cost_ff    <= {2'b00, req_tdata[31:16]};
            edge_ok_ff <= in_ok;
            last_ff    <= req_tlast;
         end
         tdpmc_pkg::OP_U_LATCH: begin
            du_ff <= $signed(dist_rd_ff);
         end
         tdpmc_pkg::OP_AUG_FWD: begin
            p_ff <= pred_rd_ff;
         end
         tdpmc_pkg::OP_AUG_BACK: begin
            fwd_ff <= edge_rd_ff;
         end
         tdpmc_pkg::OP_AUG_WFWD: begin
            back_ff <= edge_rd_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 8'd2;
         clr_addr_ff   <= '0;
         n_ff          <= '0;
         round_ff      <= '0;
         steps_ff      <= '0;
         u_ff          <= '0;
         v_ff          <= '0;
         now_ff        <= '0;
         changed_ff    <= 1'b0;
         reach_ff      <= '0;
         paths_ff      <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_found_ff  <= 1'b0;
         rsp_cost_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready && (op != tdpmc_pkg::OP_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (op)
            tdpmc_pkg::OP_CLEAR_STEP: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);  // wraps to zero at the end
            end
            tdpmc_pkg::OP_RUN_START: begin
               n_ff     <= n_sat;
               paths_ff <= (n_sat == CNT_W'(1)) ? 2'd2 : 2'd0;
               sum_ff   <= '0;
            end
            tdpmc_pkg::OP_PASS_START: begin
               reach_ff    <= MAX_NODES'(1);
               round_ff    <= CNT_W'(1);
               u_ff        <= '0;
               v_ff        <= '0;
               changed_ff  <= 1'b0;
            end
            tdpmc_pkg::OP_REL_EVAL: begin
               if (relax) begin
                  reach_ff[v_ff] <= 1'b1;
                  changed_ff     <= 1'b1;
               end
               v_ff <= status.v_last ? '0 : v_ff + NODE_W'(1);
            end
            tdpmc_pkg::OP_NEXT_U: begin
               u_ff <= u_ff + NODE_W'(1);
               v_ff <= '0;
            end
            tdpmc_pkg::OP_NEXT_ROUND: begin
               u_ff       <= '0;
               v_ff       <= '0;
               round_ff   <= round_ff + CNT_W'(1);
               changed_ff <= 1'b0;
            end
            tdpmc_pkg::OP_AUG_START: begin
               paths_ff <= paths_ff + 2'd1;
               now_ff   <= dest;
               steps_ff <= '0;
            end
            tdpmc_pkg::OP_AUG_WFWD: begin
               sum_ff <= sum_ff + SW'(fwd_cost_s);
            end
            tdpmc_pkg::OP_AUG_WBACK: begin
               now_ff   <= p_ff;
               steps_ff <= steps_ff + CNT_W'(1);
            end
            tdpmc_pkg::OP_RESULT: begin
               rsp_valid_ff <= 1'b1;
               rsp_found_ff <= (paths_ff == 2'd2);
               if (paths_ff != 2'd2 || sum_ff < 0) begin
                  rsp_cost_ff <= '0;
               end else if (sum_ff > $signed({3'b000, tdpmc_pkg::COST_LIMIT})) begin
                  rsp_cost_ff <= tdpmc_pkg::COST_LIMIT;
               end else begin
                  rsp_cost_ff <= tdpmc_pkg::SUM_W'(sum_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign status.clr_last   = (clr_addr_ff == '1);
   assign status.item_last  = last_ff;
   assign status.n_small    = (node_count_ff < 8'd2);
   assign status.u_reach    = reach_ff[u_ff];
   assign status.u_last     = (CNT_W'(u_ff) == n_ff - CNT_W'(1));
   assign status.v_last     = (CNT_W'(v_ff) == n_ff - CNT_W'(1));
   assign status.round_last = (round_ff == n_ff - CNT_W'(1));
   assign status.changed    = changed_ff;
   assign status.dest_reach = reach_ff[dest];
   assign status.aug_done   = (now_ff == '0) || (steps_ff >= n_ff);
   assign status.two_paths  = (paths_ff == 2'd2);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cost_ff;
   assign rsp_tuser  = rsp_found_ff;

   `TDPMC_ASSERT(a_cost_needs_found, (rsp_valid_ff && !rsp_found_ff) |-> (rsp_cost_ff == '0), "cost without found")
   `TDPMC_NEVER(a_paths_bound, paths_ff == 2'd3, "more than two paths")
   `TDPMC_ASSERT(a_source_reach, $past(op == tdpmc_pkg::OP_PASS_START) |-> reach_ff[0], "source not reachable")
   `TDPMC_NEVER(a_result_overrun, (op == tdpmc_pkg::OP_RESULT) && rsp_valid_ff && !rsp_tready, "result overwritten")

endmodule

/* rtl/tdpmc_ctrl.sv */
// ---------------------------------------------------------------------------
// tdpmc_ctrl
// sequencer for edge loading, bellman-ford passes, augmentation, result and clearing
// ---------------------------------------------------------------------------
module tdpmc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  tdpmc_pkg::tdpmc_status_type status,
   output tdpmc_pkg::tdpmc_op_type     op
);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_BACK,
      ST_RUN,
      ST_PASS,
      ST_ROUND_U,
      ST_U_READ,
      ST_U_LATCH,
      ST_REL_ISSUE,
      ST_REL_EVAL,
      ST_U_END,
      ST_PASS_END,
      ST_AUG_CHECK,
      ST_AUG_PRED,
      ST_AUG_FWD,
      ST_AUG_BACK,
      ST_AUG_WFWD,
      ST_AUG_WBACK,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = tdpmc_pkg::OP_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            op = tdpmc_pkg::OP_CLEAR_STEP;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op       = tdpmc_pkg::OP_LOAD_FWD;
               state_in = ST_LOAD_BACK;
            end
         end
         ST_LOAD_BACK: begin
            op       = tdpmc_pkg::OP_LOAD_BACK;
            state_in = status.item_last ? ST_RUN : ST_IDLE;
         end
         ST_RUN: begin
            op       = tdpmc_pkg::OP_RUN_START;
            state_in = status.n_small ? ST_RESULT : ST_PASS;
         end
         ST_PASS: begin
            op       = tdpmc_pkg::OP_PASS_START;
            state_in = ST_ROUND_U;
         end
         ST_ROUND_U: begin
            state_in = status.u_reach ? ST_U_READ : ST_U_END;
         end
         ST_U_READ: begin
            op       = tdpmc_pkg::OP_U_READ;
            state_in = ST_U_LATCH;
         end
         ST_U_LATCH: begin
            op       = tdpmc_pkg::OP_U_LATCH;
            state_in = ST_REL_ISSUE;
         end
         ST_REL_ISSUE: begin
            op       = tdpmc_pkg::OP_REL_ISSUE;
            state_in = ST_REL_EVAL;
         end
         ST_REL_EVAL: begin
            op       = tdpmc_pkg::OP_REL_EVAL;
            state_in = status.v_last ? ST_U_END : ST_REL_ISSUE;
         end
         ST_U_END: begin
            if (!status.u_last) begin
               op       = tdpmc_pkg::OP_NEXT_U;
               state_in = ST_ROUND_U;
            end else if (!status.changed || status.round_last) begin
               state_in = ST_PASS_END;
            end else begin
               op       = tdpmc_pkg::OP_NEXT_ROUND;
               state_in = ST_ROUND_U;
            end
         end
         ST_PASS_END: begin
            if (status.dest_reach) begin
               op       = tdpmc_pkg::OP_AUG_START;
               state_in = ST_AUG_CHECK;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_AUG_CHECK: begin
            if (!status.aug_done) state_in = ST_AUG_PRED;
            else if (status.two_paths) state_in = ST_RESULT;
            else state_in = ST_PASS;
         end
         ST_AUG_PRED: begin
            op       = tdpmc_pkg::OP_AUG_PRED;
            state_in = ST_AUG_FWD;
         end
         ST_AUG_FWD: begin
            op       = tdpmc_pkg::OP_AUG_FWD;
            state_in = ST_AUG_BACK;
         end
         ST_AUG_BACK: begin
            op       = tdpmc_pkg::OP_AUG_BACK;
            state_in = ST_AUG_WFWD;
         end
         ST_AUG_WFWD: begin
            op       = tdpmc_pkg::OP_AUG_WFWD;
            state_in = ST_AUG_WBACK;
         end
         ST_AUG_WBACK: begin
            op       = tdpmc_pkg::OP_AUG_WBACK;
            state_in = ST_AUG_CHECK;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               op       = tdpmc_pkg::OP_RESULT;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

/* rtl/two_disjoint_paths_min_cost_core.sv */
// ---------------------------------------------------------------------------
// two_disjoint_paths_min_cost_core
// least total cost of a pair of edge-disjoint paths from node 1 to node node_count
// ---------------------------------------------------------------------------
// edge transfer: two writes into the single-port edge memory, forward then backward
// compute after the last edge: up to two bellman-ford passes, each of at most (n-1)
//   rounds over the reachable nodes, and an augmentation along each path found
// then a sweep over all 4**clog2(MAX_NODES) entries (16384 at default) clears the edge
//   memory, one entry a cycle; the same sweep runs after reset
// reset is synchronous; node_count resets to 2, input is held off while busy
module two_disjoint_paths_min_cost_core #(
   parameter int MAX_NODES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // from_node, to_node, edge_cost
   input  logic        req_tuser,   // edge_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // total_cost
   output logic        rsp_tuser,   // found
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   tdpmc_pkg::tdpmc_op_type     op;
   tdpmc_pkg::tdpmc_status_type status;

   tdpmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   tdpmc_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

/* tb/tb_two_disjoint_paths_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_two_disjoint_paths_checker
// watches the edge, result and register ports, predicts the least cost of a pair
// of edge-disjoint paths per graph and compares every result transfer
// ---------------------------------------------------------------------------
module tb_two_disjoint_paths_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // from_node, to_node, edge_cost
   input  logic        req_tuser,   // edge_present
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // total_cost
   input  logic        rsp_tuser,   // found
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          fail_count,
   output int          results_pending
);

   localparam int NODES = 128;

   typedef struct packed {
      logic                        found;
      logic [tdpmc_pkg::SUM_W-1:0] total;
   } path_result_type;

   path_result_type result_q[$];
   logic [7:0]      node_cfg;
   int              cost_m[0:NODES*NODES-1];
   bit              usable_m[0:NODES*NODES-1];
   longint          node_dist[0:NODES-1];
   bit              reach[0:NODES-1];
   int              pred[0:NODES-1];

   // one bellman-ford pass from node 0, true if node n-1 is reached
   function automatic bit shortest_pass(int n);
      bit     changed;
      longint cand;
      for (int i = 0; i < NODES; i++) begin
         reach[i] = 0;
         pred[i] = 0;
      end
      node_dist[0] = 0;
      reach[0] = 1;
      for (int r = 1; r < n; r++) begin
         changed = 0;
         for (int u = 0; u < n; u++) begin
            if (!reach[u]) continue;
            for (int v = 0; v < n; v++) begin
               if (!usable_m[u*NODES+v]) continue;
               cand = node_dist[u] + longint'(cost_m[u*NODES+v]);
               if (!reach[v] || cand < node_dist[v]) begin
                  node_dist[v] = cand;
                  reach[v] = 1;
                  pred[v] = u;
                  changed = 1;
               end
            end
         end
         if (!changed) break;
      end
      return reach[n-1];
   endfunction

   function automatic path_result_type solve_graph();
      int              n, paths, now, steps, p;
      longint          sum;
      bit              ok;
      path_result_type res;
      n = node_cfg;
      if (n > NODES) n = NODES;
      paths = 0;
      sum = 0;
      if (n == 0) begin
         ok = 0;
      end else if (n == 1) begin
         ok = 1;
      end else begin
         while (paths < 2) begin
            if (!shortest_pass(n)) break;
            paths++;
            // reverse the residual edges along the path
            now = n - 1;
            steps = 0;
            while (now != 0 && steps < n) begin
               p = pred[now];
               sum += cost_m[p*NODES+now];
               usable_m[p*NODES+now] = 0;
               cost_m[now*NODES+p] = -cost_m[p*NODES+now];
               cost_m[p*NODES+now] = 0;
               now = p;
               steps++;
            end
         end
         ok = (paths == 2);
      end
      if (!ok || sum < 0) sum = 0;
      if (sum > longint'(tdpmc_pkg::COST_LIMIT)) sum = longint'(tdpmc_pkg::COST_LIMIT);
      for (int i = 0; i < NODES*NODES; i++) usable_m[i] = 0;
      res.found = ok;
      res.total = sum[tdpmc_pkg::SUM_W-1:0];
      return res;
   endfunction

   assign results_pending = result_q.size();

   always @(posedge clock) begin
      path_result_type exp_res;
      int              a, b;
      if (reset) begin
         fail_count = 0;
         node_cfg <= 8'd2;
         result_q.delete();
         for (int i = 0; i < NODES*NODES; i++) begin
            usable_m[i] = 0;
            cost_m[i] = 0;
         end
      end else begin
         if (csr_wr_en) node_cfg <= csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $error("unexpected result transfer: found %0d total_cost %0d",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               exp_res = result_q.pop_front();
               if (rsp_tuser !== exp_res.found) begin
                  $error("found: expected %0d actual %0d", exp_res.found, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== exp_res.total) begin
                  $error("total_cost: expected %0d actual %0d", exp_res.total, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            a = req_tdata[7:0];
            b = req_tdata[15:8];
            if (req_tuser && a >= 1 && b >= 1 && a <= NODES && b <= NODES) begin
               usable_m[(a-1)*NODES+b-1] = 1;
               usable_m[(b-1)*NODES+a-1] = 1;
               cost_m[(a-1)*NODES+b-1] = int'(req_tdata[31:16]);
               cost_m[(b-1)*NODES+a-1] = int'(req_tdata[31:16]);
            end
            if (req_tlast) result_q.insert(result_q.size(), solve_graph());
         end
      end
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives directed graphs, then graphs of random edges under several node counts with
// random idling on both channels except in one phase; the checker predicts and compares the results
// ---------------------------------------------------------------------------
module tb_top;

   localparam int DRAIN_CYCLES = 17000;     // clearing sweep of the edge memory
   localparam int STALL_LIMIT  = 12000000;  // slowest compute of a large graph
   localparam int ITEM_TARGET  = 950;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // from_node, to_node, edge_cost
   logic        req_tuser;   // edge_present
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // total_cost
   logic        rsp_tuser;   // found
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   int          fail_count;
   int          results_pending;
   bit          idle_on;
   int          items_sent;
   int          stall_cycles;
   int          node_now;

   two_disjoint_paths_min_cost_core dut (.*);

   tb_two_disjoint_paths_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !idle_on || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("two_disjoint_paths_min_cost_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_edge(bit present, logic [7:0] a, logic [7:0] b,
                            logic [15:0] cost, bit last);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cost, b, a};
      req_tuser  <= present;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // let every result arrive and the clearing sweep finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_nodes(logic [7:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      node_now = (value > 128) ? 128 : value;
   endtask

   function automatic logic [15:0] pick_cost();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_node(int n);
      case ($urandom_range(19))
         0: return 8'd0;
         1: return 8'($urandom_range(255, 129));
         2: return 8'($urandom_range(128, 1));
         default: return 8'($urandom_range((n < 2) ? 2 : n, 1));
      endcase
   endfunction

   // random graph; large node counts get a shallow graph to keep the run short
   task automatic random_graph(int edges);
      int mid;
      for (int i = 0; i < edges; i++) begin
         if (node_now > 32) begin
            mid = $urandom_range(node_now - 1, 2);
            if (i % 2 == 0) push_edge(1'b1, 8'd1, 8'(mid), pick_cost(), 1'b0);
            else push_edge(1'b1, 8'(mid), 8'(node_now), pick_cost(), 1'b0);
         end else begin
            push_edge($urandom_range(15) != 0, pick_node(node_now),
                      pick_node(node_now), pick_cost(), 1'b0);
         end
      end
      push_edge($urandom_range(3) != 0, pick_node(node_now), pick_node(node_now),
                pick_cost(), 1'b1);
   endtask

   initial begin
      logic [7:0] phase_nodes[12];
      int         phase_start;
      phase_nodes = '{4, 0, 1, 6, 128, 3, 255, 8, 16, 5, 2, 12};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_on     = 1'b1;
      items_sent  = 0;
      node_now    = 2;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: two nodes, then a square with a repeated edge
      push_edge(1'b1, 8'd1, 8'd2, 16'd7, 1'b1);
      push_edge(1'b0, 8'd0, 8'd0, 16'd0, 1'b1);
      push_edge(1'b1, 8'd1, 8'd2, 16'hFFFF, 1'b0);
      push_edge(1'b1, 8'd2, 8'd1, 16'd3, 1'b0);
      push_edge(1'b1, 8'd1, 8'd1, 16'd0, 1'b1);
      set_nodes(8'd4);
      push_edge(1'b1, 8'd1, 8'd2, 16'd1, 1'b0);
      push_edge(1'b1, 8'd2, 8'd4, 16'd1, 1'b0);
      push_edge(1'b1, 8'd1, 8'd3, 16'd2, 1'b0);
      push_edge(1'b1, 8'd3, 8'd4, 16'd9, 1'b0);
      push_edge(1'b1, 8'd4, 8'd3, 16'd2, 1'b0);
      push_edge(1'b1, 8'd2, 8'd3, 16'd1, 1'b0);
      push_edge(1'b1, 8'd0, 8'd4, 16'd1, 1'b0);
      push_edge(1'b1, 8'd200, 8'd1, 16'd1, 1'b0);
      push_edge(1'b1, 8'd1, 8'd100, 16'd1, 1'b0);
      push_edge(1'b1, 8'd3, 8'd3, 16'd5, 1'b0);
      push_edge(1'b0, 8'd1, 8'd4, 16'd0, 1'b1);
      push_edge(1'b1, 8'd1, 8'd4, 16'hFFFF, 1'b0);
      push_edge(1'b1, 8'd1, 8'd2, 16'hFFFF, 1'b0);
      push_edge(1'b1, 8'd2, 8'd4, 16'hFFFF, 1'b1);

      for (int p = 0; items_sent < ITEM_TARGET; p++) begin
         set_nodes((p < 12) ? phase_nodes[p] : 8'($urandom_range(10, 2)));
         idle_on = (p != 2);
         phase_start = items_sent;
         if (node_now > 32) begin
            random_graph(6);
            random_graph(3);
         end else begin
            while (items_sent - phase_start < 80)
               random_graph($urandom_range(40, 4));
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("two_disjoint_paths_min_cost_core: match");
      end else begin
         $display("two_disjoint_paths_min_cost_core: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/tdpmc_pkg.sv
rtl/tdpmc_dp.sv
rtl/tdpmc_ctrl.sv
rtl/two_disjoint_paths_min_cost_core.sv
tb/tb_two_disjoint_paths_checker.sv
tb/tb_top.sv
